>>> sv/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;

    localparam int unsigned NumStages = 15;
    localparam int unsigned StgW      = $clog2(NumStages);

    localparam logic [31:0] RawOffset = 32'd8388608;
    localparam logic [31:0] TempBase  = 32'd2500 << 15;
    localparam logic [31:0] CfBase    = 32'd2097152;
    localparam logic [31:0] PresBase  = 32'd99880;
    localparam logic [31:0] C2Offset  = 32'd256;
    localparam logic [31:0] FracMask  = 32'h0000_07FF;

    // Per-variant constants: second sensor version, then original
    localparam logic [31:0] K1V1 = 32'd4459;
    localparam logic [31:0] K4V1 = 32'd120586;
    localparam logic [31:0] K5V1 = 32'd4443;
    localparam logic [31:0] K7V1 = 32'd166426;
    localparam logic [31:0] K8V1 = 32'd7180;
    localparam logic [31:0] K1V0 = 32'd4418;
    localparam logic [31:0] K4V0 = 32'd211288;
    localparam logic [31:0] K5V0 = 32'd0;
    localparam logic [31:0] K7V0 = 32'd285594;
    localparam logic [31:0] K8V0 = 32'd7209;

    typedef enum logic [1:0] {
        REG_CAL_LOW  = 2'd0,
        REG_CAL_MID  = 2'd1,
        REG_CAL_HIGH = 2'd2,
        REG_VARIANT  = 2'd3
    } t_reg_idx;

    // Coefficients with their constant offsets already folded in
    typedef struct packed {
        logic [31:0] c0s;   // c0 << 4
        logic [31:0] p1;    // c1 + k1
        logic [31:0] p2;    // c2 - 256
        logic [31:0] c3;
        logic [31:0] p4s;   // (c4 + k4) << 4
        logic [31:0] p5;    // c5 - k5
        logic [31:0] c6;
        logic [31:0] kk;    // c7 + k7
        logic [31:0] p8;    // c8 + k8
        logic [31:0] c9;
        logic [31:0] c10;
        logic [31:0] c11;
        logic [31:0] c12;
    } t_coef;

    typedef struct packed {
        logic [31:0] up;
        logic [31:0] dt;
        logic [31:0] dt2;
        logic [31:0] rt;
        logic [31:0] x01;
        logic [31:0] x02;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] e;
        logic [31:0] f;
        logic        neg;
    } t_data;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

    // One pipeline stage; idx is a constant at each instance
    function automatic t_data stage(input logic [StgW-1:0] idx, input t_data d,
                                    input t_coef k);
        t_data o;
        logic [31:0] diff;
        o = d;
        diff = d.e - d.c;
        case (idx)
            StgW'(0): o.dt = asr(d.a - RawOffset, 5'd4) + k.c0s;
            StgW'(1): begin
                o.a = k.p1 * d.dt;
                o.b = k.p2 * d.dt;
                o.c = k.c3 * d.dt;
            end
            StgW'(2): begin
                o.x01 = asr(d.a, 5'd1);
                o.b   = asr(d.b, 5'd14) * d.dt;
                o.c   = asr(d.c, 5'd18) * d.dt;
            end
            StgW'(3): begin
                o.x02 = asr(d.b, 5'd4);
                o.c   = asr(d.c, 5'd18) * d.dt;
            end
            StgW'(4): begin
                o.rt  = asr(TempBase - d.x01 - d.x02 - d.c, 5'd15);
                o.dt2 = asr(d.x01 + d.x02 + d.c, 5'd12);
            end
            StgW'(5): begin
                o.a = k.p5 * d.dt2;
                o.b = k.c6 * d.dt2;
                o.c = k.p8 * d.dt2;
                o.e = k.c9 * d.dt2;
                o.f = k.c12 * d.dt2;
            end
            StgW'(6): begin
                o.b = asr(asr(d.b, 5'd16) * d.dt2, 5'd2);
                o.c = asr(d.c, 5'd10);
                o.e = asr(asr(d.e, 5'd17) * d.dt2, 5'd12);
                o.f = asr(CfBase + d.f, 5'd3);
            end
            StgW'(7): begin
                o.a   = asr(d.a + d.b, 5'd10) + k.p4s;
                o.neg = diff[31];
                o.b   = (($signed(d.e) >= $signed(d.c))) ? diff : d.c - d.e;
                o.e   = d.f * k.c10;
                o.f   = d.f * k.c11;
            end
            StgW'(8): begin
                o.a = asr((d.up - RawOffset) - d.a, 5'd3);
                o.c = asr(d.b, 5'd11) * k.kk;
                o.b = (d.b & FracMask) * k.kk;
            end
            StgW'(9): begin
                o.c = d.neg ? asr(32'd0 - d.c - asr(d.b, 5'd11), 5'd11) + k.kk
                            : asr(d.c + asr(d.b, 5'd11), 5'd11) + k.kk;
            end
            StgW'(10): begin
                o.b = asr(d.c, 5'd11) * d.a;
                o.c = (d.c & FracMask) * d.a;
            end
            StgW'(11): o.a = asr(d.b + asr(d.c, 5'd11), 5'd10);
            StgW'(12): begin
                o.e = asr(d.e, 5'd17) * d.a;
                o.f = asr(d.f, 5'd15) * d.a;
            end
            StgW'(13): begin
                o.e = asr(d.e, 5'd2);
                o.f = asr(d.f, 5'd18) * d.a;
            end
            StgW'(14): o.a = asr(d.e + d.f, 5'd15) + d.a + PresBase;
            default: o = d;
        endcase
        return o;
    endfunction

endpackage

>>> sv/bpc_coef.sv
`timescale 1ns / 1ps
module bpc_coef (
    input  logic [63:0]         i_cal_low,
    input  logic [63:0]         i_cal_mid,
    input  logic [31:0]         i_cal_high,
    input  logic                i_variant,
    output bpc_pkg::t_coef      o_coef
);

    logic [15:0] w0, w1, w2, w3, w4, w5, w6, w7, w8, w9;
    logic [31:0] c4, c7;

    assign w0 = i_cal_low[15:0];
    assign w1 = i_cal_low[31:16];
    assign w2 = i_cal_low[47:32];
    assign w3 = i_cal_low[63:48];
    assign w4 = i_cal_mid[15:0];
    assign w5 = i_cal_mid[31:16];
    assign w6 = i_cal_mid[47:32];
    assign w7 = i_cal_mid[63:48];
    assign w8 = i_cal_high[15:0];
    assign w9 = i_cal_high[31:16];

    always_comb begin
        // Unpack with the selected layout
        if (i_variant) begin
            c4 = {14'd0, w3, w0[1:0]};
            c7 = {13'd0, w6, w5[2:0]};
            o_coef.c12 = {27'd0, w0[3:2], w7[2:0]};
        end else begin
            c4 = {15'd0, w3, w5[0]};
            c7 = {14'd0, w6, w0[3:2]};
            o_coef.c12 = {27'd0, w5[2:1], w7[2:0]};
        end
        o_coef.c0s = {16'd0, w0[15:4], 4'd0};
        o_coef.p1  = {21'd0, w1[15:8], w2[2:0]}
                     + (i_variant ? bpc_pkg::K1V1 : bpc_pkg::K1V0);
        o_coef.p2  = {23'd0, w1[7:0], w4[0]} - bpc_pkg::C2Offset;
        o_coef.c3  = {19'd0, w2[15:3]};
        o_coef.p4s = (c4 + (i_variant ? bpc_pkg::K4V1 : bpc_pkg::K4V0)) << 4;
        o_coef.p5  = {17'd0, w4[15:1]} - (i_variant ? bpc_pkg::K5V1 : bpc_pkg::K5V0);
        o_coef.c6  = {19'd0, w5[15:3]};
        o_coef.kk  = c7 + (i_variant ? bpc_pkg::K7V1 : bpc_pkg::K7V0);
        o_coef.p8  = {19'd0, w7[15:3]} + (i_variant ? bpc_pkg::K8V1 : bpc_pkg::K8V0);
        o_coef.c9  = {18'd0, w8[15:2]};
        o_coef.c10 = {22'd0, w9[15:8], w8[1:0]};
        o_coef.c11 = {24'd0, w9[7:0]};
    end

endmodule

>>> sv/bpc_pipe.sv
`timescale 1ns / 1ps
module bpc_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpc_pkg::t_coef      i_coef,
    input  logic                i_valid,
    input  logic [23:0]         i_up,
    input  logic [23:0]         i_ut,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_pres,
    output logic [31:0]         o_temp
);

    localparam int unsigned N = bpc_pkg::NumStages;

    bpc_pkg::t_data r_st [N];
    bpc_pkg::t_data n_st [N];
    bpc_pkg::t_data in_d;
    logic [N-1:0]   r_v;
    logic [N:0]     en;

    always_comb begin
        in_d    = '0;
        in_d.up = {8'd0, i_up};
        in_d.a  = {8'd0, i_ut};
    end

    // A stage advances when it is empty or the one after it advances
    always_comb begin
        en[N] = !i_stall;
        for (int k = N - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stg
        if (g == 0) begin : g_first
            assign n_st[g] = bpc_pkg::stage(bpc_pkg::StgW'(g), in_d, i_coef);
        end else begin : g_rest
            assign n_st[g] = bpc_pkg::stage(bpc_pkg::StgW'(g), r_st[g-1], i_coef);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (en[g]) begin
                r_v[g] <= (g == 0) ? i_valid : r_v[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[g]) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[N-1];
    assign o_pres  = r_st[N-1].a;
    assign o_temp  = r_st[N-1].rt;

`ifndef SYNTH
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v[0] && o_valid))
        else $error("input stalled with room in the pipeline");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("item out right after reset");
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted item lost at first stage");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pres) && $stable(o_temp)))
        else $error("stalled result dropped or changed");
`endif

endmodule

>>> sv/barometric_pressure_compensation_unit.sv
`timescale 1ns / 1ps
// Channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------------
// input    | i_valid  | o_stall  | i_raw_pressure, i_raw_temperature
// output   | o_valid  | i_stall  | o_pressure_pa, o_temperature_centi
// config   | i_cfg_we | -        | i_cfg_idx, i_cfg_data
//
// 15-stage pipeline: one item per cycle unless the pipeline is full and stalled.
// Stage depth is set by one 32x32 truncating multiply per stage.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the
// calibration words and selects the second sensor version formula.
// Each stage holds while full and the stage after it holds; empty stages
// keep filling, so bubbles close up behind a stalled result.
module barometric_pressure_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_raw_pressure,
    input  logic [23:0] i_raw_temperature,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_pressure_pa,
    output logic signed [31:0] o_temperature_centi
);

    logic [63:0]    r_cal_low;
    logic [63:0]    r_cal_mid;
    logic [31:0]    r_cal_high;
    logic           r_variant;
    bpc_pkg::t_coef coef;
    logic [31:0]    pres, temp;

    // Configuration registers; writes must only arrive while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low  <= '0;
            r_cal_mid  <= '0;
            r_cal_high <= '0;
            r_variant  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (bpc_pkg::t_reg_idx'(i_cfg_idx))
                bpc_pkg::REG_CAL_LOW:  r_cal_low  <= i_cfg_data;
                bpc_pkg::REG_CAL_MID:  r_cal_mid  <= i_cfg_data;
                bpc_pkg::REG_CAL_HIGH: r_cal_high <= i_cfg_data[31:0];
                bpc_pkg::REG_VARIANT:  r_variant  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Coefficients are static between writes, so every stage reads them live
    bpc_coef u_coef (
        .i_cal_low  (r_cal_low),
        .i_cal_mid  (r_cal_mid),
        .i_cal_high (r_cal_high),
        .i_variant  (r_variant),
        .o_coef     (coef)
    );

    bpc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_valid (i_valid),
        .i_up    (i_raw_pressure),
        .i_ut    (i_raw_temperature),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pres  (pres),
        .o_temp  (temp)
    );

    assign o_pressure_pa       = $signed(pres);
    assign o_temperature_centi = $signed(temp);

endmodule
